// ===== rtl/telegram_ccm_mic_check_macros.svh =====
// assertion helpers for the rtl
`ifndef TELEGRAM_CCM_MIC_CHECK_MACROS_SVH
`define TELEGRAM_CCM_MIC_CHECK_MACROS_SVH
`ifndef SYNTH
`define TMC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define TMC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define TMC_ASSERT(label, clk, rst, prop)
`define TMC_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/tmc_pkg.sv =====
`timescale 1ns / 1ps
package tmc_pkg;
   localparam int MAX_BYTES_DEFAULT = 32;
   localparam int BUF_DEPTH = 30;
   localparam int Q_DEPTH = 2;
   localparam int NUM_ROUNDS = 10;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_LEN    = 3'd1;
   localparam logic [2:0] ST_COMM   = 3'd2;
   localparam logic [2:0] ST_REPLAY = 3'd3;
   localparam logic [2:0] ST_BADSIG = 3'd4;

   localparam logic [1:0] REG_KEY_HIGH = 2'd0;
   localparam logic [1:0] REG_KEY_LOW  = 2'd1;
   localparam logic [1:0] REG_ADDRESS  = 2'd2;

   localparam logic [7:0] LEN_COMM  = 8'd29;
   localparam logic [7:0] LEN_MIN   = 8'd11;
   localparam logic [7:0] SIG_BYTES = 8'd4;
   localparam logic [7:0] AAD_ONE_BLOCK = 8'd14;
   localparam logic [7:0] B0_FLAGS  = 8'h49;
   localparam logic [7:0] A0_FLAGS  = 8'h01;

   typedef struct packed {
      logic [2:0]   pre_status;
      logic [31:0]  counter;
      logic         two_blocks;
      logic [127:0] b1;
      logic [127:0] b2;
      logic [31:0]  sig;
   } job_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction
endpackage

// ===== rtl/tmc_if.sv =====
`timescale 1ns / 1ps
interface tmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] telegram_byte;
   logic       last_byte;
   modport source (output valid, telegram_byte, last_byte, input ready);
   modport sink (input valid, telegram_byte, last_byte, output ready);
endinterface

interface tmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] sequence_number;
   modport source (output valid, status, sequence_number, input ready);
   modport sink (input valid, status, sequence_number, output ready);
endinterface

// ===== rtl/tmc_front.sv =====
`timescale 1ns / 1ps
module tmc_front #(
   parameter int MAX_BYTES = tmc_pkg::MAX_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   tmc_req_if.sink          req_if,
   input  logic             q_full,
   output logic             q_push,
   output tmc_pkg::job_type q_job
);
   import tmc_pkg::*;

   logic [7:0] buf_ff [BUF_DEPTH];
   logic [7:0] buf_in [BUF_DEPTH];
   logic [7:0] blk [BUF_DEPTH];
   logic [5:0] count_ff, count_in;
   logic [31:0] sig_ff, sig_in;
   logic accept;
   logic [6:0] total;
   logic [7:0] len, aad;
   logic len_bad;

   assign req_if.ready = !q_full;
   assign accept = req_if.valid && req_if.ready;
   assign total = {1'b0, count_ff} + 7'd1;
   assign sig_in = {sig_ff[23:0], req_if.telegram_byte};

   always_comb begin
      for (int j = 0; j < BUF_DEPTH; j++) begin
         buf_in[j] = (accept && count_ff == 6'(j)) ? req_if.telegram_byte : buf_ff[j];
      end
      len = buf_in[0];
      aad = len - (SIG_BYTES - 8'd1);
      len_bad = ({2'b0, total} != {1'b0, len} + 9'd1) || (total > 7'(MAX_BYTES));
      for (int j = 0; j < BUF_DEPTH; j++) begin
         blk[j] = (8'(j) < aad) ? buf_in[j] : 8'h00;
      end
      q_job.counter = '0;
      for (int i = 0; i < 4; i++) begin
         // counter bytes not received read as zero
         q_job.counter[8*i +: 8] = (total > 7'(4 + i)) ? buf_in[4 + i] : 8'h00;
      end
      if (len_bad) begin
         q_job.pre_status = ST_LEN;
      end else if (len == LEN_COMM) begin
         q_job.pre_status = ST_COMM;
      end else if (len < LEN_MIN) begin
         q_job.pre_status = ST_LEN;
      end else begin
         q_job.pre_status = ST_OK;
      end
      q_job.two_blocks = aad > AAD_ONE_BLOCK;
      q_job.b1 = '0;
      q_job.b1[119:112] = aad;
      for (int j = 0; j < 14; j++) begin
         q_job.b1[111 - 8*j -: 8] = blk[j];
      end
      for (int j = 14; j < BUF_DEPTH; j++) begin
         q_job.b2[127 - 8*(j - 14) -: 8] = blk[j];
      end
      q_job.sig = sig_in;
      q_push = accept && req_if.last_byte;
      if (!accept) begin
         count_in = count_ff;
      end else if (req_if.last_byte) begin
         count_in = '0;
      end else if (count_ff == 6'd63) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sig_ff <= sig_in;
         for (int j = 0; j < BUF_DEPTH; j++) begin
            buf_ff[j] <= buf_in[j];
         end
      end
   end
endmodule

// ===== rtl/tmc_queue.sv =====
`timescale 1ns / 1ps
module tmc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tmc_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             job_valid,
   output tmc_pkg::job_type pop_job
);
   import tmc_pkg::*;

   localparam int AW = $clog2(Q_DEPTH);

   job_type entry_ff [Q_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] fill_ff;

   assign full = fill_ff == (AW + 1)'(Q_DEPTH);
   assign job_valid = fill_ff != '0;
   assign pop_job = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         fill_ff <= fill_ff + (AW + 1)'(push) - (AW + 1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end
endmodule

// ===== rtl/tmc_aes.sv =====
`timescale 1ns / 1ps
module tmc_aes (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] key,
   input  logic [127:0] blk_in,
   output logic         done,
   output logic [127:0] blk_out
);
   import tmc_pkg::*;

   logic [127:0] state_ff, rk_ff, rk_next;
   logic [7:0] rcon_ff;
   logic [3:0] round_ff;
   logic busy_ff, done_ff;

   function automatic logic [127:0] key_step(logic [127:0] rk, logic [7:0] rcon);
      logic [31:0] t, w0, w1, w2, w3;
      t = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      w0 = rk[127:96] ^ t;
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [127:0] enc_round(logic [127:0] s, logic last_round);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[c*4 + i] = SBOX[s[127 - 8*(((c + i) % 4) * 4 + i) -: 8]];
         end
      end
      if (!last_round) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[c*4];
            a1 = t[c*4 + 1];
            a2 = t[c*4 + 2];
            a3 = t[c*4 + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[c*4]     = a0 ^ all ^ xtime(a0 ^ a1);
            t[c*4 + 1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[c*4 + 2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[c*4 + 3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = t[i];
      end
      return r;
   endfunction

   assign rk_next = key_step(rk_ff, rcon_ff);
   assign done = done_ff;
   assign blk_out = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= busy_ff && round_ff == 4'(NUM_ROUNDS);
         if (start) begin
            busy_ff <= 1'b1;
            round_ff <= 4'd1;
         end else if (busy_ff) begin
            round_ff <= round_ff + 4'd1;
            if (round_ff == 4'(NUM_ROUNDS)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         state_ff <= blk_in ^ key;
         rk_ff <= key;
         rcon_ff <= 8'h01;
      end else if (busy_ff) begin
         state_ff <= enc_round(state_ff, round_ff == 4'(NUM_ROUNDS)) ^ rk_next;
         rk_ff <= rk_next;
         rcon_ff <= xtime(rcon_ff);
      end
   end
endmodule

// ===== rtl/tmc_back.sv =====
`timescale 1ns / 1ps
`include "telegram_ccm_mic_check_macros.svh"
module tmc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   input  logic             job_valid,
   input  tmc_pkg::job_type job,
   output logic             pop,
   tmc_rsp_if.source        rsp_if
);
   import tmc_pkg::*;

   typedef enum logic [2:0] {IDLE, RUN_B0, RUN_B1, RUN_B2, RUN_A0} state_type;

   state_type state_ff;
   job_type job_ff;
   logic [63:0] key_high_ff, key_low_ff;
   logic [47:0] addr_ff;
   logic [31:0] last_ff;
   logic [127:0] x_ff, tag;
   logic rsp_valid_ff;
   logic [2:0] status_ff;
   logic [31:0] seq_ff;
   logic aes_start, aes_done;
   logic [127:0] aes_in, aes_out;

   function automatic logic [127:0] ctr_block(logic [7:0] flags, logic [47:0] addr,
                                              logic [31:0] ctr);
      return {flags, addr[7:0], addr[15:8], addr[23:16], addr[31:24], addr[39:32],
              addr[47:40], ctr[7:0], ctr[15:8], ctr[23:16], ctr[31:24], 40'h0};
   endfunction

   assign pop = state_ff == IDLE && job_valid && !rsp_valid_ff;
   assign tag = x_ff ^ aes_out;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = status_ff;
   assign rsp_if.sequence_number = seq_ff;

   always_comb begin
      aes_start = 1'b0;
      aes_in = aes_out ^ job_ff.b1;
      case (state_ff)
         IDLE: begin
            aes_start = pop && job.pre_status == ST_OK && job.counter > last_ff;
            aes_in = ctr_block(B0_FLAGS, addr_ff, job.counter);
         end
         RUN_B0: begin
            aes_start = aes_done;
            aes_in = aes_out ^ job_ff.b1;
         end
         RUN_B1: begin
            aes_start = aes_done;
            aes_in = job_ff.two_blocks ? aes_out ^ job_ff.b2
                                       : ctr_block(A0_FLAGS, addr_ff, job_ff.counter);
         end
         RUN_B2: begin
            aes_start = aes_done;
            aes_in = ctr_block(A0_FLAGS, addr_ff, job_ff.counter);
         end
         default: begin
            aes_start = 1'b0;
         end
      endcase
   end

   tmc_aes u_aes (
      .clock   (clock),
      .reset   (reset),
      .start   (aes_start),
      .key     ({key_high_ff, key_low_ff}),
      .blk_in  (aes_in),
      .done    (aes_done),
      .blk_out (aes_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff <= '0;
         key_high_ff <= '0;
         key_low_ff <= '0;
         addr_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_KEY_HIGH: key_high_ff <= csr_wdata;
               REG_KEY_LOW:  key_low_ff <= csr_wdata;
               REG_ADDRESS:  addr_ff <= csr_wdata[47:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (pop) begin
                  job_ff <= job;
                  seq_ff <= job.counter;
                  if (job.pre_status != ST_OK) begin
                     status_ff <= job.pre_status;
                     rsp_valid_ff <= 1'b1;
                  end else if (job.counter <= last_ff) begin
                     status_ff <= ST_REPLAY;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= RUN_B0;
                  end
               end
            end
            RUN_B0: begin
               if (aes_done) begin
                  state_ff <= RUN_B1;
               end
            end
            RUN_B1: begin
               if (aes_done) begin
                  x_ff <= aes_out;
                  state_ff <= job_ff.two_blocks ? RUN_B2 : RUN_A0;
               end
            end
            RUN_B2: begin
               if (aes_done) begin
                  x_ff <= aes_out;
                  state_ff <= RUN_A0;
               end
            end
            RUN_A0: begin
               if (aes_done) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= IDLE;
                  if (tag[127:96] == job_ff.sig) begin
                     status_ff <= ST_OK;
                     last_ff <= job_ff.counter;
                  end else begin
                     status_ff <= ST_BADSIG;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   `TMC_ASSERT_NEVER(a_done_idle, clock, reset, aes_done && state_ff == IDLE)
   `TMC_ASSERT_NEVER(a_rsp_during_run, clock, reset, rsp_valid_ff && state_ff != IDLE)
   `TMC_ASSERT(a_counter_grows, clock, reset, (last_ff != $past(last_ff)) |-> (last_ff > $past(last_ff)))
endmodule

// ===== rtl/telegram_ccm_mic_check.sv =====
`timescale 1ns / 1ps
// bytes are taken one per cycle while the two-entry telegram queue has room
// a result for a length error, commissioning telegram or replay comes without an aes pass,
// otherwise after three or four passes of the aes round loop
// a checked telegram is popped only while the aes loop is idle and no result waits
// synchronous reset clears counters, queue, stored last counter and the key and address registers
module telegram_ccm_mic_check #(
   parameter int MAX_BYTES = tmc_pkg::MAX_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tmc_req_if.sink     req_if,
   tmc_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import tmc_pkg::*;

   job_type push_job, pop_job;
   logic q_full, q_push, q_pop, job_valid;

   tmc_front #(.MAX_BYTES(MAX_BYTES)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   tmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .job_valid (job_valid),
      .pop_job   (pop_job)
   );

   tmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_valid (job_valid),
      .job       (pop_job),
      .pop       (q_pop),
      .rsp_if    (rsp_if)
   );
endmodule

// ===== tb/tb_telegram_ccm_mic_check.sv =====
`timescale 1ns / 1ps
module tb_telegram_ccm_mic_check;
   import tmc_pkg::*;

   localparam int BUF_BYTES = 32;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] seq_no;
   } verdict_type;

   typedef struct packed {
      logic [7:0] tg_byte;
      logic       last;
      logic       typed;
      logic [2:0] status;
      logic [31:0] seq_no;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   tmc_req_if req ();
   tmc_rsp_if rsp ();

   telegram_ccm_mic_check dut (
      .clock(clock), .reset(reset), .req_if(req.sink), .rsp_if(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the block state
   logic [63:0] key_hi, key_lo;
   logic [47:0] dev_addr;
   logic [7:0]  tg_buf [BUF_BYTES];
   int unsigned rx_count;
   logic [31:0] good_counter;

   verdict_type verdict_q [$];
   verdict_type typed_q [$];
   int errors = 0;
   int unsigned cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned verdicts_seen = 0;
   int unsigned status_hits [5];
   int send_idle = 0;
   int recv_idle = 0;

   function automatic logic [7:0] dbl(logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes128(logic [127:0] k, logic [127:0] d);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] f, rc, a0, a1, a2, a3, al;
      logic [127:0] o;
      int i, c, r;
      rc = 8'h01;
      for (i = 0; i < 16; i++) rk[i] = k[127 - 8 * i -: 8];
      for (i = 16; i < 176; i += 4) begin
         for (c = 0; c < 4; c++) w[c] = rk[i - 4 + c];
         if ((i % 16) == 0) begin
            f = w[0];
            w[0] = SBOX[w[1]] ^ rc;
            w[1] = SBOX[w[2]];
            w[2] = SBOX[w[3]];
            w[3] = SBOX[f];
            rc = dbl(rc);
         end
         for (c = 0; c < 4; c++) rk[i + c] = rk[i - 16 + c] ^ w[c];
      end
      for (i = 0; i < 16; i++) s[i] = d[127 - 8 * i -: 8] ^ rk[i];
      for (r = 1; r <= 10; r++) begin
         for (c = 0; c < 4; c++)
            for (i = 0; i < 4; i++) t[c * 4 + i] = SBOX[s[((c + i) % 4) * 4 + i]];
         if (r != 10) begin
            for (c = 0; c < 4; c++) begin
               a0 = t[c * 4]; a1 = t[c * 4 + 1]; a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
               al = a0 ^ a1 ^ a2 ^ a3;
               t[c * 4]     = a0 ^ al ^ dbl(a0 ^ a1);
               t[c * 4 + 1] = a1 ^ al ^ dbl(a1 ^ a2);
               t[c * 4 + 2] = a2 ^ al ^ dbl(a2 ^ a3);
               t[c * 4 + 3] = a3 ^ al ^ dbl(a3 ^ a0);
            end
         end
         for (i = 0; i < 16; i++) s[i] = t[i] ^ rk[r * 16 + i];
      end
      for (i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
      return o;
   endfunction

   // first four tag bytes, byte 0 in the top bits
   function automatic logic [31:0] ccm_tag(logic [7:0] tb [BUF_BYTES], int len,
                                           logic [31:0] ctr);
      logic [127:0] k, x, a0;
      logic [103:0] nonce;
      logic [7:0]   blk [32];
      int i, aad, nblk;
      k = {key_hi, key_lo};
      for (i = 0; i < 6; i++) nonce[103 - 8 * i -: 8] = dev_addr[8 * i +: 8];
      for (i = 0; i < 4; i++) nonce[55 - 8 * i -: 8] = ctr[8 * i +: 8];
      nonce[23:0] = '0;
      x = aes128(k, {B0_FLAGS, nonce, 16'h0000});
      aad = len - 3;
      for (i = 0; i < 32; i++) blk[i] = 8'h00;
      blk[1] = aad[7:0];
      for (i = 0; i < aad && i < 30; i++) blk[2 + i] = tb[i];
      nblk = (aad + 2 <= 16) ? 1 : 2;
      for (i = 0; i < nblk * 16; i++) begin
         x[127 - 8 * (i % 16) -: 8] ^= blk[i];
         if ((i % 16) == 15) x = aes128(k, x);
      end
      a0 = aes128(k, {A0_FLAGS, nonce, 16'h0000});
      x = x ^ a0;
      return x[127:96];
   endfunction

   function automatic logic [7:0] rx_byte(int i, int total);
      return (i < total && i < BUF_BYTES) ? tg_buf[i] : 8'h00;
   endfunction

   task automatic predict(logic [7:0] b, logic last, output logic done,
                          output verdict_type v);
      int total, len, i;
      logic [31:0] ctr, tag, sig;
      done = 1'b0;
      v = '0;
      if (rx_count < BUF_BYTES) tg_buf[rx_count] = b;
      total = int'(rx_count) + 1;
      if (rx_count < 63) rx_count++;
      if (!last) return;
      rx_count = 0;
      done = 1'b1;
      len = int'(rx_byte(0, total));
      ctr = '0;
      for (i = 0; i < 4; i++) ctr[8 * i +: 8] = rx_byte(4 + i, total);
      v.seq_no = ctr;
      if (total != len + 1 || total > BUF_BYTES) v.status = ST_LEN;
      else if (len == LEN_COMM) v.status = ST_COMM;
      else if (len < LEN_MIN) v.status = ST_LEN;
      else if (ctr <= good_counter) v.status = ST_REPLAY;
      else begin
         tag = ccm_tag(tg_buf, len, ctr);
         for (i = 0; i < 4; i++) sig[31 - 8 * i -: 8] = rx_byte(len - 3 + i, total);
         if (tag != sig) v.status = ST_BADSIG;
         else begin
            v.status = ST_OK;
            good_counter = ctr;
         end
      end
   endtask

   // accepted byte: predict, and use a typed expectation where the table has one
   logic     pending_typed = 1'b0;
   always @(posedge clock) begin
      logic done;
      verdict_type v;
      cycles <= cycles + 1;
      if (!reset && req.valid && req.ready) begin
         predict(req.telegram_byte, req.last_byte, done, v);
         if (done) begin
            if (typed_q.size() > 0 && pending_typed) verdict_q.push_back(typed_q.pop_front());
            else verdict_q.push_back(v);
         end
      end
      if (!reset && rsp.valid && rsp.ready) begin
         verdicts_seen <= verdicts_seen + 1;
         if (verdict_q.size() == 0) begin
            $error("unexpected result status=%0d seq=%h", rsp.status, rsp.sequence_number);
            errors++;
         end else begin
            v = verdict_q.pop_front();
            if (v.status < 5) status_hits[v.status]++;
            if (rsp.status !== v.status) begin
               $error("status: expected %0d, got %0d", v.status, rsp.status);
               errors++;
            end
            if (rsp.sequence_number !== v.seq_no) begin
               $error("sequence_number: expected %h, got %h", v.seq_no, rsp.sequence_number);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      req.valid = 1'b0;
      req.telegram_byte = '0;
      req.last_byte = 1'b0;
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic push_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.telegram_byte <= b;
      req.last_byte <= last;
      do @(posedge clock); while (!req.ready);
      bytes_sent++;
   endtask

   task automatic push_telegram(logic [7:0] tb [$]);
      foreach (tb[i]) push_byte(tb[i], i == tb.size() - 1);
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_KEY_HIGH: key_hi = val;
         REG_KEY_LOW:  key_lo = val;
         REG_ADDRESS:  dev_addr = val[47:0];
         default: ;
      endcase
   endtask

   // one random telegram, mostly well formed with a correct signature
   task automatic random_telegram(int kind);
      logic [7:0] tb [$];
      logic [7:0] arr [BUF_BYTES];
      logic [31:0] ctr, tag;
      int len, n, i, pick;
      pick = $urandom_range(99);
      if (kind == 1) begin
         n = 70;
         len = $urandom_range(255);
      end else if (pick < 10) begin
         len = LEN_COMM;
         n = len + 1;
      end else if (pick < 20) begin
         len = $urandom_range(255);
         n = $urandom_range(1, 40);
      end else if (pick < 25) begin
         len = $urandom_range(0, 10);
         n = len + 1;
      end else begin
         do len = $urandom_range(11, 31); while (len == LEN_COMM);
         n = len + 1;
      end
      if (pick >= 25 && pick < 35) ctr = $urandom_range(0, 3) == 0 ? good_counter
                                          : good_counter - $urandom_range(0, 5);
      else if (kind == 2) ctr = 32'hffff_ffff;
      else if (good_counter > 32'hfff0_0000) ctr = $urandom();
      else ctr = good_counter + $urandom_range(1, 65535);
      for (i = 0; i < BUF_BYTES; i++) arr[i] = 8'($urandom_range(255));
      arr[0] = 8'(len);
      for (i = 0; i < 4; i++) arr[4 + i] = ctr[8 * i +: 8];
      if (n == len + 1 && len >= LEN_MIN && len < BUF_BYTES && $urandom_range(99) < 85) begin
         tag = ccm_tag(arr, len, ctr);
         for (i = 0; i < 4; i++) arr[len - 3 + i] = tag[31 - 8 * i -: 8];
      end
      for (i = 0; i < n; i++) tb.push_back(i < BUF_BYTES ? arr[i] : 8'($urandom_range(255)));
      push_telegram(tb);
   endtask

   row_type directed [$];

   initial begin
      int p, r;
      logic [63:0] kh, kl, ad;
      key_hi = '0; key_lo = '0; dev_addr = '0;
      rx_count = 0; good_counter = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-byte telegrams, a short bogus one, length ten, replay of zero
      directed.push_back('{8'h00, 1'b1, 1'b1, ST_LEN, 32'h0});
      directed.push_back('{8'hff, 1'b1, 1'b1, ST_LEN, 32'h0});
      directed.push_back('{8'h02, 1'b0, 1'b0, 3'd0, 32'h0});
      directed.push_back('{8'haa, 1'b0, 1'b0, 3'd0, 32'h0});
      directed.push_back('{8'hbb, 1'b1, 1'b1, ST_LEN, 32'h0});
      directed.push_back('{8'h0a, 1'b0, 1'b0, 3'd0, 32'h0});
      for (r = 1; r < 10; r++)
         directed.push_back('{8'(r), 1'b0, 1'b0, 3'd0, 32'h0});
      directed.push_back('{8'h0a, 1'b1, 1'b1, ST_LEN, 32'h07060504});
      directed.push_back('{8'h0b, 1'b0, 1'b0, 3'd0, 32'h0});
      for (r = 1; r < 11; r++)
         directed.push_back('{(r >= 4 && r <= 7) ? 8'h00 : 8'hff, 1'b0, 1'b0, 3'd0, 32'h0});
      directed.push_back('{8'h00, 1'b1, 1'b1, ST_REPLAY, 32'h0});
      foreach (directed[i]) begin
         if (directed[i].last) begin
            pending_typed = directed[i].typed;
            if (directed[i].typed)
               typed_q.push_back('{directed[i].status, directed[i].seq_no});
         end
         push_byte(directed[i].tg_byte, directed[i].last);
      end
      settle();
      pending_typed = 1'b0;

      for (p = 0; p < 6; p++) begin
         case (p)
            0: begin kh = '0; kl = '0; ad = '0; end
            1: begin kh = '1; kl = '1; ad = '1; end
            default: begin
               kh = {$urandom(), $urandom()};
               kl = {$urandom(), $urandom()};
               ad = {$urandom(), $urandom()};
            end
         endcase
         write_reg(REG_KEY_HIGH, kh);
         write_reg(REG_KEY_LOW, kl);
         write_reg(REG_ADDRESS, ad);
         send_idle = (p < 2) ? 36 : (p < 4) ? 64 : 0;
         recv_idle = (p < 2) ? 64 : (p < 4) ? 36 : 0;
         if (p == 1) random_telegram(1);
         if (p == 5) random_telegram(2);
         r = bytes_sent;
         while (bytes_sent - r < 90) random_telegram(0);
         // hold off until the block has answered everything
         settle();
      end

      $display("sent %0d bytes, checked %0d results over six key and address settings",
               bytes_sent, verdicts_seen);
      $display("accepted %0d, length %0d, commissioning %0d, replay %0d, bad signature %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4]);
      if (errors == 0 && verdict_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
